// ===== hdl/cartridge_bank_mapper_macros.svh =====
// assertion macros shared by the mapper files
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CBM_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mapper assertion failed");

// next-cycle implication
`define CBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mapper assertion failed");

`else

`define CBM_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define CBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/cbm_pkg.sv =====
package cbm_pkg;

  // request kinds
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_PRG   = 2'd1,
    MODE_CHR   = 2'd2
  } cbm_mode_e;

  // cpu write regions, address bits 15:13
  localparam logic [2:0] REGION_SELECT = 3'd4;
  localparam logic [2:0] REGION_BANK   = 3'd5;
  localparam logic [2:0] REGION_CHR_HI = 3'd6;
  localparam logic [2:0] REGION_CTRL   = 3'd7;

  // fixed program banks for the upper two windows
  localparam logic [7:0] PRG_FIXED_LO = 8'hFE;
  localparam logic [7:0] PRG_FIXED_HI = 8'hFF;

  localparam int unsigned NUM_BANKS = 8;

  typedef struct packed {
    logic [NUM_BANKS-1:0][7:0] bank;
    logic [7:0]                chr_hi;
    logic [7:0]                ctrl;
  } cbm_state_t;

  typedef struct packed {
    logic       en;
    logic [2:0] region;
    logic [7:0] data;
  } cbm_wr_t;

endpackage

// ===== hdl/cartridge_bank_mapper.sv =====
// channel   | dir | tdata (low bit up)                          | tuser
// ----------+-----+---------------------------------------------+-------------------
// s_axis    | in  | address[15:0], write_data[23:16]            | mode[1:0]
// m_axis    | out | physical_address[20:0], mirroring[21], pad  | address_valid
//
// one request per cycle while m_axis accepts results; each request passes through
// an input register, then one pass of bank selection and bit composition into
// the result register. bank state updates when a request leaves the input register.
// rst_ni clears valids and all bank state asynchronously.
// an m_axis stall holds the result; the input register still takes one more request.
`include "cartridge_bank_mapper_macros.svh"

module cartridge_bank_mapper #(
  parameter int unsigned PRG_BANK_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // address[15:0], write_data[23:16]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // physical_address[20:0], mirroring[21]
  output logic        m_axis_tuser_o    // address_valid
);
  import cbm_pkg::*;

  // input register
  logic        in_vld_q;
  logic [1:0]  in_mode_q;
  logic [15:0] in_addr_q;
  logic [7:0]  in_data_q;

  // result register
  logic        out_vld_q;
  logic [20:0] out_phys_q;
  logic        out_ok_q;
  logic        out_mirr_q;

  logic        advance;
  logic        s_fire;
  logic        move;

  cbm_state_t  state;
  cbm_wr_t     wr;
  logic        mirr;
  logic [20:0] phys;
  logic        ok;

  // result slot frees when empty or being taken
  assign advance = !out_vld_q || m_axis_tready_i;
  assign move    = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mode_q <= s_axis_tuser_i;
      in_addr_q <= s_axis_tdata_i[15:0];
      in_data_q <= s_axis_tdata_i[23:16];
    end
  end

  // cpu writes reach the bank state only as the request moves on
  assign wr.en     = move && (in_mode_q == MODE_WRITE);
  assign wr.region = in_addr_q[15:13];
  assign wr.data   = in_data_q;

  cbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .state_o     (state),
    .mirroring_o (mirr)
  );

  cbm_xlate #(
    .PRG_BANK_BITS (PRG_BANK_BITS)
  ) u_xlate (
    .state_i   (state),
    .mode_i    (in_mode_q),
    .address_i (in_addr_q),
    .phys_o    (phys),
    .valid_o   (ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_phys_q <= phys;
      out_ok_q   <= ok;
      out_mirr_q <= mirr;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_mirr_q, out_phys_q};
  assign m_axis_tuser_o  = out_ok_q;

  `CBM_ASSERT_IMPLIES(a_full_stall, clk_i, rst_ni, in_vld_q && out_vld_q && !m_axis_tready_i, !s_axis_tready_o)
  `CBM_ASSERT_NEXT(a_move_fills, clk_i, rst_ni, move, out_vld_q)
  `CBM_ASSERT_IMPLIES(a_miss_zero, clk_i, rst_ni, out_vld_q && !out_ok_q, out_phys_q == 21'd0)
  `CBM_ASSERT_IMPLIES(a_write_no_hit, clk_i, rst_ni, in_vld_q && in_mode_q == MODE_WRITE, !ok)

endmodule

// ===== hdl/cbm_regs.sv =====
`include "cartridge_bank_mapper_macros.svh"

module cbm_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbm_pkg::cbm_wr_t    wr_i,
  output cbm_pkg::cbm_state_t state_o,
  output logic                mirroring_o
);
  import cbm_pkg::*;

  logic [2:0] sel_q, sel_d;
  cbm_state_t st_q, st_d;

  always_comb begin
    sel_d = sel_q;
    st_d  = st_q;
    if (wr_i.en) begin
      case (wr_i.region)
        REGION_SELECT: sel_d = wr_i.data[2:0];
        REGION_BANK:   st_d.bank[sel_q] = wr_i.data;
        REGION_CHR_HI: st_d.chr_hi = wr_i.data;
        REGION_CTRL:   st_d.ctrl = wr_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      st_q  <= '0;
    end else begin
      sel_q <= sel_d;
      st_q  <= st_d;
    end
  end

  assign state_o = st_q;
  // mirroring reflects the control byte after this request's update
  assign mirroring_o = ~st_d.ctrl[0];

  `CBM_ASSERT_NEXT(a_ctrl_load, clk_i, rst_ni, wr_i.en && wr_i.region == REGION_CTRL, st_q.ctrl == $past(wr_i.data))
  `CBM_ASSERT_NEXT(a_sel_load, clk_i, rst_ni, wr_i.en && wr_i.region == REGION_SELECT, sel_q == $past(wr_i.data[2:0]))
  `CBM_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !wr_i.en, st_q == $past(st_q) && sel_q == $past(sel_q))

endmodule

// ===== hdl/cbm_xlate.sv =====
module cbm_xlate #(
  parameter int unsigned PRG_BANK_BITS = 8
) (
  input  cbm_pkg::cbm_state_t state_i,
  input  logic [1:0]          mode_i,
  input  logic [15:0]         address_i,
  output logic [20:0]         phys_o,
  output logic                valid_o
);
  import cbm_pkg::*;

  localparam logic [7:0] PrgMask = 8'((9'd1 << PRG_BANK_BITS) - 9'd1);

  logic [7:0] prg_bank;
  logic [7:0] chr_hi;
  logic [2:0] chr_idx;
  logic [8:0] chr_bank;

  always_comb begin
    case (address_i[14:13])
      2'd0:    prg_bank = state_i.bank[0];
      2'd1:    prg_bank = state_i.bank[1];
      2'd2:    prg_bank = PRG_FIXED_LO;
      default: prg_bank = PRG_FIXED_HI;
    endcase
    prg_bank = prg_bank & PrgMask;

    chr_hi   = state_i.ctrl[1] ? state_i.chr_hi : 8'h00;
    // 2KB slots pair onto registers 2 and 3
    chr_idx  = address_i[12] ? address_i[12:10] : {2'b01, address_i[11]};
    chr_bank = {chr_hi[chr_idx], state_i.bank[chr_idx]};

    phys_o  = '0;
    valid_o = 1'b0;
    case (cbm_mode_e'(mode_i))
      MODE_PRG: begin
        if (address_i[15]) begin
          phys_o  = {prg_bank, address_i[12:0]};
          valid_o = 1'b1;
        end
      end
      MODE_CHR: begin
        if (address_i[15:13] == 3'd0) begin
          if (address_i[12]) begin
            phys_o = 21'({chr_bank, address_i[9:0]});
          end else begin
            phys_o = 21'({chr_bank[8:1], address_i[10:0]});
          end
          valid_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
